@@ rtl/sltl_pkg.sv @@
// Shared types, year-word ROM and lookup functions for the solar to lunar date converter.
package sltl_pkg;

    localparam int YEAR_ENTRIES_DEF = 189;
    localparam int ROM_ROWS         = 189;
    localparam int WALK_STEPS       = 12;

    localparam logic [3:0] SLOT_FIRST = 4'd1;
    localparam logic [3:0] SLOT_LAST  = 4'd13;
    localparam logic [3:0] SLOT_TWELVE = 4'd12;

    // year word: [23:16] byte0, [15:8] byte1, [7:0] byte2
    localparam logic [23:0] LUNAR_ROM [0:ROM_ROWS-1] = '{
        24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
        24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
        24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
        24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
        24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
        24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
        24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
        24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
        24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
        24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
        24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
        24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h7AD53C,
        24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
        24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
        24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
        24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
        24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
        24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
        24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
        24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
        24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
        24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
        24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
        24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
        24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
        24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
        24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
        24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
        24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
        24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
        24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
        24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
        24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
        24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
        24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
        24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
        24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
        24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A
    };

    typedef struct packed {
        logic       oor;
        logic       cent;
        logic [6:0] year;
        logic [7:0] idx;
        logic [8:0] doy;
    } dec_t;

    typedef struct packed {
        logic        oor;
        logic        cent;
        logic [6:0]  year;
        logic [23:0] word;
        logic        fwd;
        logic [8:0]  rem;
        logic [3:0]  slot;
    } walk_t;

    function automatic logic [23:0] rom_word(input logic [7:0] idx);
        if (idx < 8'(ROM_ROWS)) begin
            return LUNAR_ROM[idx];
        end
        return 24'h0;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // 1 = long month (30 days)
    function automatic logic slot_long(input logic [23:0] w, input logic [3:0] slot);
        logic b;
        unique case (slot)
            4'd1:    b = w[19];
            4'd2:    b = w[18];
            4'd3:    b = w[17];
            4'd4:    b = w[16];
            4'd5:    b = w[15];
            4'd6:    b = w[14];
            4'd7:    b = w[13];
            4'd8:    b = w[12];
            4'd9:    b = w[11];
            4'd10:   b = w[10];
            4'd11:   b = w[9];
            4'd12:   b = w[8];
            4'd13:   b = w[7];
            default: b = 1'b0;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/sltl_decode.sv @@
// Stage 1: BCD decode, range checks, table index and day of year.
module sltl_decode #(
    parameter int YEAR_ENTRIES = sltl_pkg::YEAR_ENTRIES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic          century_flag,
    input  logic [7:0]    year_bcd,
    input  logic [4:0]    month_bcd,
    input  logic [5:0]    day_bcd,
    output logic          out_valid,
    output sltl_pkg::dec_t out_dec
);

    logic           valid_reg;
    sltl_pkg::dec_t dec_reg, dec_next;
    logic [6:0]     year;
    logic [4:0]     month;
    logic [5:0]     day;
    logic           bad_bcd;
    logic [7:0]     idx;
    logic [8:0]     doy;

    always_comb begin
        bad_bcd = (year_bcd[3:0] > 4'd9) || (year_bcd[7:4] > 4'd9) ||
                  (month_bcd[3:0] > 4'd9) || (day_bcd[3:0] > 4'd9);
        year  = (7'(year_bcd[7:4]) << 3) + (7'(year_bcd[7:4]) << 1) + 7'(year_bcd[3:0]);
        month = (month_bcd[4] ? 5'd10 : 5'd0) + 5'(month_bcd[3:0]);
        day   = (6'(day_bcd[5:4]) << 3) + (6'(day_bcd[5:4]) << 1) + 6'(day_bcd[3:0]);
        idx   = century_flag ? (8'(year) - 8'd1) : (8'(year) + 8'd99);
        doy   = sltl_pkg::days_before(month[3:0]) + 9'(day) - 9'd1;
        if (month > 5'd2 && year[1:0] == 2'b00) begin
            doy = doy + 9'd1;
        end
        dec_next.oor  = bad_bcd || month == 5'd0 || month > 5'd12 ||
                        day == 6'd0 || day > 6'd31 ||
                        (century_flag && year == 7'd0) ||
                        idx >= 8'(YEAR_ENTRIES);
        dec_next.cent = century_flag;
        dec_next.year = year;
        dec_next.idx  = idx;
        dec_next.doy  = doy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            dec_reg <= dec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

endmodule

@@ rtl/sltl_lookup.sv @@
// Stage 2: year-word ROM reads, Spring Festival compare, walk setup.
module sltl_lookup (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  sltl_pkg::dec_t  in_dec,
    output logic            out_valid,
    output sltl_pkg::walk_t out_walk
);

    logic            valid_reg;
    sltl_pkg::walk_t walk_reg, walk_next;
    logic [23:0]     wc, wp;
    logic [7:0]      sf;
    logic            fwd;

    always_comb begin
        wc  = sltl_pkg::rom_word(in_dec.idx);
        wp  = sltl_pkg::rom_word(in_dec.idx - 8'd1);
        sf  = (wc[6:5] == 2'd1) ? (8'(wc[4:0]) - 8'd1) : (8'(wc[4:0]) + 8'd30);
        fwd = in_dec.doy >= 9'(sf);
        walk_next.fwd = fwd;
        if (fwd) begin
            walk_next.oor  = in_dec.oor;
            walk_next.cent = in_dec.cent;
            walk_next.year = in_dec.year;
            walk_next.word = wc;
            walk_next.rem  = in_dec.doy - 9'(sf);
            walk_next.slot = sltl_pkg::SLOT_FIRST;
        end else begin
            walk_next.oor  = in_dec.oor || in_dec.idx == 8'd0;
            if (!in_dec.cent && in_dec.year == 7'd0) begin
                walk_next.cent = 1'b1;
                walk_next.year = 7'd99;
            end else begin
                walk_next.cent = in_dec.cent;
                walk_next.year = in_dec.year - 7'd1;
            end
            walk_next.word = wp;
            walk_next.rem  = 9'(sf) - in_dec.doy;
            walk_next.slot = (wp[23:20] == 4'd0) ? sltl_pkg::SLOT_TWELVE
                                                 : sltl_pkg::SLOT_LAST;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            walk_reg <= walk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_walk  = walk_reg;

endmodule

@@ rtl/sltl_walk_step.sv @@
// One month step of the lunar month walk, forward or backward.
module sltl_walk_step (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  sltl_pkg::walk_t in_walk,
    output logic            out_valid,
    output sltl_pkg::walk_t out_walk
);

    logic            valid_reg;
    sltl_pkg::walk_t walk_reg, walk_next;
    logic [8:0]      len;

    always_comb begin
        len       = sltl_pkg::slot_long(in_walk.word, in_walk.slot) ? 9'd30 : 9'd29;
        walk_next = in_walk;
        if (in_walk.fwd) begin
            if (in_walk.rem >= len && in_walk.slot < sltl_pkg::SLOT_LAST) begin
                walk_next.rem  = in_walk.rem - len;
                walk_next.slot = in_walk.slot + 4'd1;
            end
        end else begin
            if (in_walk.rem > len && in_walk.slot > sltl_pkg::SLOT_FIRST) begin
                walk_next.rem  = in_walk.rem - len;
                walk_next.slot = in_walk.slot - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            walk_reg <= walk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_walk  = walk_reg;

endmodule

@@ rtl/solar_to_lunar_date.sv @@
// Top level of the Gregorian to Chinese lunar date converter.
// Usage:
//   s_ channel takes one date request per handshake: s_tuser is the century
//   flag (1 = 19yy, 0 = 20yy); s_tdata holds BCD year, month and day.
//   m_ channel returns one result per request: m_tdata holds the binary lunar
//   year, month and day; m_tuser holds the lunar century and out_of_range.
//   Out-of-range dates return all-zero date fields with out_of_range set.
// Pipeline: stage 1 decodes BCD, stage 2 reads the year ROM, then twelve
//   month-step stages walk the lunar months, then the result register.
// Throughput: one request per cycle while the output is not stalled; the
//   twelve-step month walk is fully pipelined.
// Stalls: the whole pipeline holds while m_tvalid is high and m_tready is low;
//   s_tready is low for exactly those cycles. Nothing is dropped or repeated.
// Reset: aresetn low clears all valid bits; no request is in flight after it.
module solar_to_lunar_date #(
    parameter int YEAR_ENTRIES = sltl_pkg::YEAR_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] year_bcd, [12:8] month_bcd, [18:13] day_bcd
    input  logic        s_tuser,   // [0] century_flag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] lunar_year, [10:7] lunar_month, [15:11] lunar_day
    output logic [1:0]  m_tuser    // [0] lunar_century, [1] out_of_range
);

    localparam int N = sltl_pkg::WALK_STEPS;

    logic            en;
    logic            dec_valid, lk_valid;
    sltl_pkg::dec_t  dec;
    logic            wv [0:N];
    sltl_pkg::walk_t ww [0:N];
    logic            m_valid_reg;
    logic [15:0]     m_data_reg, m_data_next;
    logic [1:0]      m_user_reg, m_user_next;
    sltl_pkg::walk_t fin;
    logic [3:0]      leap, lm;
    logic [4:0]      len, ld;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    sltl_decode #(.YEAR_ENTRIES(YEAR_ENTRIES)) u_decode (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid), .century_flag(s_tuser),
        .year_bcd(s_tdata[7:0]), .month_bcd(s_tdata[12:8]), .day_bcd(s_tdata[18:13]),
        .out_valid(dec_valid), .out_dec(dec)
    );

    sltl_lookup u_lookup (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(dec_valid), .in_dec(dec),
        .out_valid(lk_valid), .out_walk(ww[0])
    );

    assign wv[0] = lk_valid;

    for (genvar i = 0; i < N; i++) begin : g_walk
        sltl_walk_step u_step (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(wv[i]), .in_walk(ww[i]),
            .out_valid(wv[i+1]), .out_walk(ww[i+1])
        );
    end

    always_comb begin
        fin  = ww[N];
        leap = fin.word[23:20];
        len  = sltl_pkg::slot_long(fin.word, fin.slot) ? 5'd30 : 5'd29;
        lm   = (leap == 4'd0 || fin.slot <= leap) ? fin.slot : fin.slot - 4'd1;
        ld   = fin.fwd ? (fin.rem[4:0] + 5'd1) : (len + 5'd1 - fin.rem[4:0]);
        if (fin.oor) begin
            m_data_next = 16'h0;
            m_user_next = 2'b10;
        end else begin
            m_data_next = {ld, lm, fin.year};
            m_user_next = {1'b0, fin.cent};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= wv[N];
        end
        if (en) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ rtl/sltl_checker.sv @@
// Port-level assertions for the solar to lunar date converter, bound to the top level.
module sltl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not track output stall");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 16'h0 && !m_tuser[0]))
        else $error("out of range result carries nonzero fields");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind solar_to_lunar_date sltl_checker u_sltl_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

@@ verif/testbench.sv @@
// Testbench for the solar to lunar date converter: stream requests, scoreboard check.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        bit       cent;
        bit [6:0] year;
        bit [3:0] month;
        bit [4:0] day;
        bit       oor;
    } lunar_t;

    class lunar_scoreboard;
        lunar_t pending_q[$];
        int     errors;
        int     checked;
        int     oor_seen;

        function bit [4:0] month_len(bit [23:0] w, int slot);
            return w[20 - slot] ? 5'd30 : 5'd29;
        endfunction

        function lunar_t convert(bit c, bit [7:0] yb, bit [4:0] mb, bit [5:0] db);
            int     cum [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
            lunar_t r;
            int     year, month, day, idx, sf, doy, rem, slot, len, leap, mon;
            bit [23:0] w;
            r = '{0, 0, 0, 0, 1};
            if (yb[3:0] > 9 || yb[7:4] > 9 || mb[3:0] > 9 || db[3:0] > 9)
                return r;
            year  = yb[7:4] * 10 + yb[3:0];
            month = mb[4] * 10 + mb[3:0];
            day   = db[5:4] * 10 + db[3:0];
            if (month < 1 || month > 12 || day < 1 || day > 31)
                return r;
            if (!c)
                idx = year + 99;
            else if (year == 0)
                return r;
            else
                idx = year - 1;
            if (idx >= sltl_pkg::YEAR_ENTRIES_DEF)
                return r;
            w  = sltl_pkg::LUNAR_ROM[idx];
            sf = (w[6:5] == 2'd1) ? w[4:0] - 1 : w[4:0] + 30;
            doy = cum[month - 1] + day - 1;
            if (month > 2 && year % 4 == 0)
                doy++;
            if (doy >= sf) begin
                rem  = doy - sf;
                leap = w[23:20];
                slot = 1;
                len  = month_len(w, slot);
                while (rem >= len && slot < 13) begin
                    rem -= len;
                    slot++;
                    len = month_len(w, slot);
                end
                r.day = 5'(rem + 1);
            end else begin
                rem = sf - doy;
                if (idx == 0)
                    return r;
                w = sltl_pkg::LUNAR_ROM[idx - 1];
                if (!c && year == 0) begin
                    year = 99;
                    c = 1;
                end else begin
                    year--;
                end
                leap = w[23:20];
                slot = (leap == 0) ? 12 : 13;
                len  = month_len(w, slot);
                while (rem > len && slot > 1) begin
                    rem -= len;
                    slot--;
                    len = month_len(w, slot);
                end
                r.day = 5'(len + 1 - rem);
            end
            mon = (leap == 0 || slot <= leap) ? slot : slot - 1;
            r.cent  = c;
            r.year  = 7'(year);
            r.month = 4'(mon);
            r.oor   = 0;
            return r;
        endfunction

        function void note_request(bit c, bit [23:0] data);
            pending_q.push_back(convert(c, data[7:0], data[12:8], data[18:13]));
        endfunction

        function void check_result(bit [15:0] data, bit [1:0] user);
            lunar_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time, data, user);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (e.oor)
                oor_seen++;
            if (data[6:0] != e.year || data[10:7] != e.month || data[15:11] != e.day
                    || user[0] != e.cent || user[1] != e.oor) begin
                $display("%0t: mismatch expected c=%0d y=%0d m=%0d d=%0d oor=%0d", $time,
                         e.cent, e.year, e.month, e.day, e.oor);
                $display("%0t:          actual   c=%0d y=%0d m=%0d d=%0d oor=%0d", $time,
                         user[0], data[6:0], data[10:7], data[15:11], user[1]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    lunar_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int requests = 0;

    solar_to_lunar_date dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    function bit [7:0] to_bcd(int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    task send_date(bit c, bit [7:0] yb, bit [4:0] mb, bit [5:0] db);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 0;
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tuser  <= c;
        s_tdata  <= {5'b0, db, mb, yb};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(c, {5'b0, db, mb, yb});
        requests++;
    endtask

    task send_random();
        if ($urandom_range(9) == 0)
            send_date(1'($urandom_range(1)), 8'($urandom_range(255)),
                      5'($urandom_range(31)), 6'($urandom_range(63)));
        else
            send_date(1'($urandom_range(1)), to_bcd($urandom_range(99)),
                      5'(to_bcd($urandom_range(1, 12))), 6'(to_bcd($urandom_range(1, 31))));
    endtask

    task drain();
        @(negedge aclk);
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        send_date(1'b1, 8'h01, 5'h01, 6'h01);
        send_date(1'b1, 8'h01, 5'h02, 6'h19);
        send_date(1'b1, 8'h01, 5'h02, 6'h18);
        send_date(1'b1, 8'h00, 5'h06, 6'h15);
        send_date(1'b0, 8'h89, 5'h12, 6'h31);
        send_date(1'b0, 8'h90, 5'h01, 6'h01);
        send_date(1'b0, 8'h99, 5'h12, 6'h31);
        send_date(1'b0, 8'h00, 5'h01, 6'h01);
        send_date(1'b1, 8'h99, 5'h12, 6'h31);
        send_date(1'b0, 8'hA0, 5'h01, 6'h01);
        send_date(1'b0, 8'h0F, 5'h01, 6'h01);
        send_date(1'b0, 8'h10, 5'h13, 6'h01);
        send_date(1'b0, 8'h10, 5'h00, 6'h01);
        send_date(1'b0, 8'h10, 5'h1F, 6'h01);
        send_date(1'b0, 8'h10, 5'h05, 6'h00);
        send_date(1'b0, 8'h10, 5'h05, 6'h32);
        send_date(1'b0, 8'h10, 5'h05, 6'h3F);
        send_date(1'b0, 8'h01, 5'h02, 6'h30);
        send_date(1'b0, 8'h20, 5'h03, 6'h01);
        send_date(1'b1, 8'h38, 5'h12, 6'h31);
        send_date(1'b1, 8'h39, 5'h01, 6'h25);
        send_date(1'b0, 8'h23, 5'h03, 6'h22);
        send_date(1'b1, 8'hFF, 5'h0A, 6'h2A);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 86 : 28) : 0;
            recv_idle_pct = (ph == 2) ? 86 : (ph == 3 ? 28 : 0);
            if (ph == 3)
                send_idle_pct = 28;
            for (int i = 0; i < 210; i++) begin
                if (ph == 0 && i == 60)
                    hold_cycles = 300;
                if (ph == 0 && i == 120)
                    drain();
                send_random();
            end
        end
        drain();
        repeat (20) @(posedge aclk);
        $display("Sent %0d date requests, %0d results checked (%0d out of range).",
                 requests, sb.checked, sb.oor_seen);
        $display("Covered bad BCD, coverage edges, century wrap and all idle phases.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench: errors");
        $finish;
    end
endmodule

@@ files.f @@
rtl/sltl_pkg.sv
rtl/sltl_decode.sv
rtl/sltl_lookup.sv
rtl/sltl_walk_step.sv
rtl/solar_to_lunar_date.sv
rtl/sltl_checker.sv
verif/testbench.sv
